// ===== rtl/planar_pose_dead_reckoning_macros.svh =====
// ----------------------------------------------------------------------------
// planar pose dead reckoning assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef PLANAR_POSE_DEAD_RECKONING_MACROS_SVH
`define PLANAR_POSE_DEAD_RECKONING_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PDR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PDR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/pdr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdr_pkg
// Types, constants and the control store of the planar pose dead reckoning
// block.
// ----------------------------------------------------------------------------
package pdr_pkg;

   // default parameter values
   localparam int CORDIC_STEPS_DEF   = 16;
   localparam int POSITION_WIDTH_DEF = 32;

   // cordic arithmetic
   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W   = 5;
   localparam int X_W          = 34;   // cordic x/y, q.30 with headroom
   localparam int Z_W          = 33;   // residual angle, 2^-32 turn units
   localparam int FRAC_Q       = 30;
   localparam int DELTA_W      = 16;
   localparam int ACC_W        = X_W + DELTA_W;
   localparam logic signed [X_W-1:0] CORDIC_GAIN_Q30 = X_W'(652032874);

   localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // quadrant of the heading
   typedef enum logic [1:0] {
      QUAD_0, QUAD_90, QUAD_180, QUAD_270
   } quad_type;

   // channel payloads
   typedef struct packed {
      logic                      run_start;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic signed [15:0]        delta_heading;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic signed [15:0] pose_heading;
      logic               saturated;
   } rsp_payload_type;

   // cordic unit control and status
   typedef struct packed {
      logic load;
      logic iter;
      logic quad;
   } cordic_ctl_type;

   typedef struct packed {
      logic last;
   } cordic_sts_type;

   // control word fields
   typedef enum logic [0:0] { MA_COS, MA_SIN } mul_a_type;
   typedef enum logic [0:0] { MB_DX, MB_DY } mul_b_type;
   typedef enum logic [1:0] { ACC_HOLD, ACC_LOAD_RND, ACC_ADD, ACC_SUB } acc_op_type;
   typedef enum logic [1:0] { PW_NONE, PW_X, PW_Y } pos_wr_type;
   typedef enum logic [2:0] {
      SEQ_NEXT, SEQ_ACCEPT, SEQ_LOOP, SEQ_OUT, SEQ_JUMP
   } seq_type;

   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;

   // control store addresses
   localparam pc_type UA_WAIT = 4'd0;
   localparam pc_type UA_ITER = 4'd1;
   localparam pc_type UA_QUAD = 4'd2;
   localparam pc_type UA_M1   = 4'd3;
   localparam pc_type UA_M2   = 4'd4;
   localparam pc_type UA_M3   = 4'd5;
   localparam pc_type UA_M4   = 4'd6;
   localparam pc_type UA_M5   = 4'd7;
   localparam pc_type UA_M6   = 4'd8;
   localparam pc_type UA_FIN  = 4'd9;

   typedef struct packed {
      logic           in_ready;
      cordic_ctl_type cordic;
      logic           mul_en;
      mul_a_type      mul_a;
      mul_b_type      mul_b;
      acc_op_type     acc_op;
      pos_wr_type     pos_wr;
      logic           out_wr;
      seq_type        seq;
      pc_type         target;
   } ucode_word_type;

   // control store: one word per step
   function automatic ucode_word_type ucode_rom(input pc_type pc);
      ucode_word_type w;
      w = '0;
      unique case (pc)
         UA_WAIT: begin
            w.in_ready    = 1'b1;
            w.cordic.load = 1'b1;
            w.seq         = SEQ_ACCEPT;
         end
         UA_ITER: begin
            w.cordic.iter = 1'b1;
            w.seq         = SEQ_LOOP;
            w.target      = UA_ITER;
         end
         UA_QUAD: begin
            w.cordic.quad = 1'b1;
         end
         UA_M1: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_COS;
            w.mul_b  = MB_DX;
         end
         UA_M2: begin
            w.acc_op = ACC_LOAD_RND;
            w.mul_en = 1'b1;
            w.mul_a  = MA_SIN;
            w.mul_b  = MB_DY;
         end
         UA_M3: begin
            w.acc_op = ACC_SUB;
            w.mul_en = 1'b1;
            w.mul_a  = MA_SIN;
            w.mul_b  = MB_DX;
         end
         UA_M4: begin
            w.pos_wr = PW_X;
            w.acc_op = ACC_LOAD_RND;
            w.mul_en = 1'b1;
            w.mul_a  = MA_COS;
            w.mul_b  = MB_DY;
         end
         UA_M5: begin
            w.acc_op = ACC_ADD;
         end
         UA_M6: begin
            w.pos_wr = PW_Y;
         end
         UA_FIN: begin
            w.out_wr = 1'b1;
            w.seq    = SEQ_OUT;
            w.target = UA_WAIT;
         end
         default: begin
            w.seq    = SEQ_JUMP;
            w.target = UA_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/pdr_if.sv =====
// ----------------------------------------------------------------------------
// pdr channel interfaces
// Valid/ready channels for odometry increments and pose results.
// ----------------------------------------------------------------------------
interface pdr_req_if;
   logic                     valid;
   logic                     ready;
   pdr_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pdr_rsp_if;
   logic                     valid;
   logic                     ready;
   pdr_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/pdr_cordic.sv =====
// ----------------------------------------------------------------------------
// pdr_cordic
// Rotation-mode cordic, one iteration per cycle, with quadrant fold-back.
// ----------------------------------------------------------------------------
module pdr_cordic #(
   parameter int CORDIC_STEPS = pdr_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pdr_pkg::cordic_ctl_type           ctl,
   input  logic [15:0]                       heading,
   output pdr_pkg::cordic_sts_type           sts,
   output logic signed [pdr_pkg::X_W-1:0]    cos_q30,
   output logic signed [pdr_pkg::X_W-1:0]    sin_q30
);

   localparam int N     = (CORDIC_STEPS < pdr_pkg::ATAN_ENTRIES) ?
                          CORDIC_STEPS : pdr_pkg::ATAN_ENTRIES;
   localparam int CNT_W = (N > 1) ? $clog2(N) : 1;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(N - 1);

   logic signed [pdr_pkg::X_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [pdr_pkg::Z_W-1:0] z_ff, z_in;
   logic signed [pdr_pkg::X_W-1:0] c_ff, c_in, s_ff, s_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   pdr_pkg::quad_type              q_ff, q_in;

   logic [15:0]                    hsum;
   logic signed [13:0]             resid;
   logic signed [pdr_pkg::X_W-1:0] xs, ys;
   logic signed [pdr_pkg::Z_W-1:0] atan_z;

   // nearest quadrant and residual angle
   assign hsum  = heading + 16'h2000;
   assign resid = {~hsum[13], hsum[12:0]};

   // shifted terms and table angle for this iteration
   assign xs     = x_ff >>> cnt_ff;
   assign ys     = y_ff >>> cnt_ff;
   assign atan_z = pdr_pkg::Z_W'(pdr_pkg::ATAN_TURN32[pdr_pkg::ATAN_IDX_W'(cnt_ff)]);

   assign sts.last = (cnt_ff == LAST);

   // iteration datapath
   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      cnt_in = cnt_ff;
      q_in   = q_ff;
      c_in   = c_ff;
      s_in   = s_ff;
      if (ctl.load) begin
         x_in   = pdr_pkg::CORDIC_GAIN_Q30;
         y_in   = '0;
         z_in   = pdr_pkg::Z_W'(resid) <<< 16;
         cnt_in = '0;
         q_in   = pdr_pkg::quad_type'(hsum[15:14]);
      end else if (ctl.iter) begin
         if (!z_ff[pdr_pkg::Z_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_z;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_z;
         end
         if (!sts.last) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
      if (ctl.quad) begin
         unique case (q_ff)
            pdr_pkg::QUAD_0: begin
               c_in = x_ff;
               s_in = y_ff;
            end
            pdr_pkg::QUAD_90: begin
               c_in = -y_ff;
               s_in = x_ff;
            end
            pdr_pkg::QUAD_180: begin
               c_in = -x_ff;
               s_in = -y_ff;
            end
            default: begin
               c_in = y_ff;
               s_in = -x_ff;
            end
         endcase
      end
   end

   // iteration counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // vector, angle and result registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      q_ff <= q_in;
      c_ff <= c_in;
      s_ff <= s_in;
   end

   assign cos_q30 = c_ff;
   assign sin_q30 = s_ff;

endmodule

// ===== rtl/planar_pose_dead_reckoning.sv =====
// ----------------------------------------------------------------------------
// planar_pose_dead_reckoning
// Integrates robot-frame odometry steps into a global planar pose.
// ----------------------------------------------------------------------------
// channel   dir  contents
// req_chan  in   run_start, delta_x, delta_y, delta_heading
// rsp_chan  out  pose_x, pose_y, pose_heading, saturated
//
// An item runs through the cordic iterations, the quadrant, multiply and
// final steps before its result is valid, and the next item is taken only
// at the wait step. The cordic iterations run one per cycle and the four
// products share one multiplier, all stepped by the control store.
// Reset clears the pose to the origin and returns the sequencer to its wait
// step. A result held by rsp_chan stalls the final step until it is taken.
// ----------------------------------------------------------------------------
`include "planar_pose_dead_reckoning_macros.svh"

module planar_pose_dead_reckoning #(
   parameter int CORDIC_STEPS   = pdr_pkg::CORDIC_STEPS_DEF,
   parameter int POSITION_WIDTH = pdr_pkg::POSITION_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   pdr_req_if.sink   req_chan,
   pdr_rsp_if.source rsp_chan
);

   localparam int ACC_W = pdr_pkg::ACC_W;
   localparam int MX_W  = ACC_W - pdr_pkg::FRAC_Q;
   localparam int SUM_W = (POSITION_WIDTH > 34) ? POSITION_WIDTH : 34;
   localparam logic signed [SUM_W-1:0] POS_HI = SUM_W'({(POSITION_WIDTH-1){1'b1}});
   localparam logic signed [SUM_W-1:0] POS_LO = ~POS_HI;
   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      ACC_W'(64'd1 << (pdr_pkg::FRAC_Q - 1));

   // sequencer
   pdr_pkg::pc_type         pc_ff, pc_in;
   pdr_pkg::ucode_word_type ucode;
   logic                    accept;
   logic                    slot_free;

   // cordic unit
   pdr_pkg::cordic_ctl_type        cordic_ctl;
   pdr_pkg::cordic_sts_type        cordic_sts;
   logic [15:0]                    rot_heading;
   logic signed [pdr_pkg::X_W-1:0] cos_q30, sin_q30;

   // item and pose
   logic signed [pdr_pkg::DELTA_W-1:0] dx_ff, dy_ff;
   logic [15:0]                        dh_ff;
   logic signed [31:0]                 pos_x_ff, pos_y_ff;
   logic [15:0]                        heading_ff;
   logic                               hit_ff;

   // multiply-accumulate
   logic signed [pdr_pkg::X_W-1:0]     mul_a;
   logic signed [pdr_pkg::DELTA_W-1:0] mul_b;
   logic signed [ACC_W-1:0]            prod_ff, prod_in, acc_ff, acc_in;
   logic signed [MX_W-1:0]             mx;

   // position update
   logic signed [31:0]      pos_sel;
   logic signed [SUM_W-1:0] sum, clipped;
   logic                    clip_hit;

   // result register
   logic                     rsp_valid_ff;
   pdr_pkg::rsp_payload_type rsp_payload_ff;

   // control word fetch
   assign ucode          = pdr_pkg::ucode_rom(pc_ff);
   assign req_chan.ready = ucode.in_ready && !reset;
   assign accept         = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   // next step
   always_comb begin
      pc_in = pc_ff;
      unique case (ucode.seq)
         pdr_pkg::SEQ_NEXT:   pc_in = pc_ff + 1'b1;
         pdr_pkg::SEQ_ACCEPT: pc_in = accept ? pc_ff + 1'b1 : pc_ff;
         pdr_pkg::SEQ_LOOP:   pc_in = cordic_sts.last ? pc_ff + 1'b1 : ucode.target;
         pdr_pkg::SEQ_OUT:    pc_in = slot_free ? ucode.target : pc_ff;
         default:             pc_in = ucode.target;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= pdr_pkg::UA_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // cordic control, heading cleared by a run start
   always_comb begin
      cordic_ctl      = ucode.cordic;
      cordic_ctl.load = ucode.cordic.load && accept;
   end
   assign rot_heading = req_chan.payload.run_start ? 16'h0000 : heading_ff;

   pdr_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cordic_ctl),
      .heading (rot_heading),
      .sts     (cordic_sts),
      .cos_q30 (cos_q30),
      .sin_q30 (sin_q30)
   );

   // shared multiplier
   assign mul_a   = (ucode.mul_a == pdr_pkg::MA_COS) ? cos_q30 : sin_q30;
   assign mul_b   = (ucode.mul_b == pdr_pkg::MB_DX) ? dx_ff : dy_ff;
   assign prod_in = mul_a * mul_b;

   // accumulator
   always_comb begin
      acc_in = acc_ff;
      case (ucode.acc_op)
         pdr_pkg::ACC_LOAD_RND: acc_in = prod_ff + ROUND_HALF;
         pdr_pkg::ACC_ADD:      acc_in = acc_ff + prod_ff;
         pdr_pkg::ACC_SUB:      acc_in = acc_ff - prod_ff;
         default:               acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ucode.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   // rounded step, added and clipped to the position range
   assign mx      = acc_ff[ACC_W-1:pdr_pkg::FRAC_Q];
   assign pos_sel = (ucode.pos_wr == pdr_pkg::PW_Y) ? pos_y_ff : pos_x_ff;
   assign sum     = SUM_W'(pos_sel) + SUM_W'(mx);

   always_comb begin
      clipped  = sum;
      clip_hit = 1'b0;
      if (sum > POS_HI) begin
         clipped  = POS_HI;
         clip_hit = 1'b1;
      end else if (sum < POS_LO) begin
         clipped  = POS_LO;
         clip_hit = 1'b1;
      end
   end

   // item capture and pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         heading_ff <= '0;
         hit_ff     <= 1'b0;
      end else begin
         if (accept) begin
            hit_ff <= 1'b0;
            if (req_chan.payload.run_start) begin
               pos_x_ff   <= '0;
               pos_y_ff   <= '0;
               heading_ff <= '0;
            end
         end
         if (ucode.pos_wr == pdr_pkg::PW_X) begin
            pos_x_ff <= clipped[31:0];
            hit_ff   <= hit_ff | clip_hit;
         end else if (ucode.pos_wr == pdr_pkg::PW_Y) begin
            pos_y_ff <= clipped[31:0];
            hit_ff   <= hit_ff | clip_hit;
         end
         if (ucode.out_wr && slot_free) begin
            heading_ff <= heading_ff + dh_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff <= req_chan.payload.delta_x;
         dy_ff <= req_chan.payload.delta_y;
         dh_ff <= req_chan.payload.delta_heading;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ucode.out_wr && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ucode.out_wr && slot_free) begin
         rsp_payload_ff.pose_x       <= pos_x_ff;
         rsp_payload_ff.pose_y       <= pos_y_ff;
         rsp_payload_ff.pose_heading <= heading_ff + dh_ff;
         rsp_payload_ff.saturated    <= hit_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // assertions
   `PDR_ASSERT_NEXT(a_accept_starts, clock, reset, accept, pc_ff == pdr_pkg::UA_ITER, "accepted item did not start the cordic pass")
   `PDR_ASSERT_IMPLY(a_iter_done, clock, reset, pc_ff == pdr_pkg::UA_QUAD, cordic_sts.last, "quadrant step before the last cordic iteration")
   `PDR_ASSERT_NEXT(a_heading_hold, clock, reset, !(ucode.out_wr && slot_free) && !(accept && req_chan.payload.run_start), $stable(heading_ff), "heading moved outside result write or run start")

endmodule
